// ----- hw/rtl/pns_pkg.sv -----
// Shared constants, widths and arithmetic helpers for the Perlin noise sampler.
`default_nettype none
package pns_pkg;

    localparam int FRAC_BITS = 24;
    localparam int CELL_BITS = 8;
    localparam int SUM_W     = FRAC_BITS + CELL_BITS;
    localparam int COORD_W   = 56;
    localparam int OFS_W     = 32;
    localparam int OUT_W     = 27;
    localparam int TBL_W     = 8;
    localparam int TBL_AW    = CELL_BITS;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_AXES  = 3;

    localparam int POLY_W = FRAC_BITS + 5;
    localparam int GRAD_W = FRAC_BITS + 3;
    localparam int LERP_W = FRAC_BITS + 4;
    localparam int SAT_W  = (LERP_W > OUT_W) ? LERP_W : OUT_W;

    localparam logic [POLY_W-1:0] FADE_C15 = POLY_W'(15) << FRAC_BITS;
    localparam logic [POLY_W-1:0] FADE_C10 = POLY_W'(10) << FRAC_BITS;
    localparam logic [POLY_W-1:0] FADE_C6  = POLY_W'(6);

    localparam logic signed [SAT_W-1:0] OUT_LIMIT = SAT_W'(1) << 25;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = CFG_IDX_W'(2);

    // Dot product of one of the twelve gradient directions with the corner offset.
    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [3:0]                 h,
        input logic signed [FRAC_BITS:0]  x,
        input logic signed [FRAC_BITS:0]  y,
        input logic signed [FRAC_BITS:0]  z
    );
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gz;
        logic signed [GRAD_W-1:0] r;
        gx = GRAD_W'(x);
        gy = GRAD_W'(y);
        gz = GRAD_W'(z);
        unique case (h)
            4'd0:  r = gx + gy;
            4'd1:  r = -gx + gy;
            4'd2:  r = gx - gy;
            4'd3:  r = -gx - gy;
            4'd4:  r = gx + gz;
            4'd5:  r = -gx + gz;
            4'd6:  r = gx - gz;
            4'd7:  r = -gx - gz;
            4'd8:  r = gy + gz;
            4'd9:  r = -gy + gz;
            4'd10: r = gy - gz;
            4'd11: r = -gy - gz;
            4'd12: r = gx + gy;
            4'd13: r = -gy + gz;
            4'd14: r = -gx + gy;
            default: r = -gy - gz;
        endcase
        return r;
    endfunction

    // lo + floor(t * (hi - lo)), with t a nonnegative fade weight.
    function automatic logic signed [LERP_W-1:0] lerp(
        input logic [FRAC_BITS:0]        t,
        input logic signed [LERP_W-1:0]  lo,
        input logic signed [LERP_W-1:0]  hi
    );
        logic signed [LERP_W:0]                 d;
        logic signed [LERP_W+FRAC_BITS+2:0]     p;
        d = (LERP_W+1)'(hi) - (LERP_W+1)'(lo);
        p = (LERP_W+FRAC_BITS+3)'($signed({1'b0, t})) * (LERP_W+FRAC_BITS+3)'(d);
        return lo + LERP_W'(p >>> FRAC_BITS);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pns_in_if.sv -----
// Input channel of the noise sampler: table writes and sample requests.
`default_nettype none
interface pns_in_if import pns_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [TBL_AW-1:0]          table_index;
    logic [TBL_W-1:0]           table_value;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;

    modport source (output valid, cmd, table_index, table_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink   (input valid, cmd, table_index, table_value, coord_x, coord_y, coord_z,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pns_out_if.sv -----
// Output channel of the noise sampler: one noise sample per transfer.
`default_nettype none
interface pns_out_if import pns_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/perlin_noise_3d_sampler_core.sv -----
// Top level of the pipelined improved 3D Perlin noise sampler.
//
//  Channel   Direction  Payload                                         Transfer when
//  i_in      sink       cmd, table_index, table_value, coord_x/y/z       valid && ready
//  o_res     source     noise_value                                     valid && ready
//  i_cfg_*   write      i_cfg_index selects offset_x/y/z, i_cfg_data     i_cfg_we high
//
// The block takes one item per clock while the output is not stalled. A sample passes
// the input registers, the three dependent permutation lookups beside the three-multiply
// fade chain, then the gradient stage and three lerp stages, the last of which is the
// output register, where the sample waits for its output transfer.
// Reset clears the stage valid bits and the offset registers; the table is not cleared.
// The whole pipeline advances together and freezes only while a finished sample
// waits in the output register and the sink is not ready.
`default_nettype none
module perlin_noise_3d_sampler_core import pns_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [OFS_W-1:0]      i_cfg_data,
    pns_in_if.sink                i_in,
    pns_out_if.source             o_res
);
    // Pipeline control. Stage n holds one item in bit n of these vectors.
    logic         w_adv;
    logic [7:1]   r_vld;
    logic [7:1]   r_cmd;
    logic         r_ovld;

    logic [OFS_W-1:0] r_ofs [NUM_AXES];

    // Stage payloads.
    logic [SUM_W-1:0]      w_coord [NUM_AXES];
    logic [SUM_W-1:0]      n_sum   [NUM_AXES];
    logic [FRAC_BITS-1:0]  r_f1 [NUM_AXES];
    logic [FRAC_BITS-1:0]  r_f2 [NUM_AXES];
    logic [FRAC_BITS-1:0]  r_f3 [NUM_AXES];
    logic [FRAC_BITS-1:0]  r_f4 [NUM_AXES];
    logic [TBL_AW-1:0]     r_h1 [NUM_AXES];
    logic [TBL_AW-1:0]     r_hy2;
    logic [TBL_AW-1:0]     r_hz2;
    logic [TBL_AW-1:0]     r_hz3;
    logic [TBL_AW-1:0]     r_tidx1, r_tidx2, r_tidx3;
    logic [TBL_W-1:0]      r_tval1, r_tval2, r_tval3;

    logic [FRAC_BITS:0]    w_fade [NUM_AXES];
    logic [FRAC_BITS:0]    r_tx5, r_ty5, r_tz5, r_ty6, r_tz6, r_tz7;

    // Permutation lookups: the first hash level, then two rows, then eight corners.
    logic [TBL_W-1:0]      w_p1a, w_p1b;
    logic [TBL_AW-1:0]     w_a1, w_b1;
    logic [TBL_W-1:0]      w_pa1, w_pa11, w_pb1, w_pb11;
    logic [TBL_AW-1:0]     w_l3a [4];
    logic [TBL_W-1:0]      w_hash [8];

    logic signed [FRAC_BITS:0]  w_pos [NUM_AXES];
    logic signed [FRAC_BITS:0]  w_neg [NUM_AXES];
    logic signed [GRAD_W-1:0]   n_grad [8];
    logic signed [GRAD_W-1:0]   r_l5 [8];
    logic signed [LERP_W-1:0]   n_x [4];
    logic signed [LERP_W-1:0]   r_x6 [4];
    logic signed [LERP_W-1:0]   n_y [2];
    logic signed [LERP_W-1:0]   r_y7 [2];
    logic signed [LERP_W-1:0]   r_res;
    logic signed [SAT_W-1:0]    w_res_ext;
    logic signed [SAT_W-1:0]    w_sat;

    logic w_we1, w_we2, w_we3;

    assign w_adv       = !r_ovld || o_res.ready;
    assign i_in.ready  = w_adv;

    // Offset registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_ofs[a] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OFFSET_X: r_ofs[0] <= i_cfg_data;
                REG_OFFSET_Y: r_ofs[1] <= i_cfg_data;
                REG_OFFSET_Z: r_ofs[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel with the items; write items leave no result behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_vld  <= {r_vld[6:1], i_in.valid};
            r_ovld <= r_vld[7] && (r_cmd[7] == CMD_SAMPLE);
        end
    end

    // Only the cell index and fraction survive, so the low sum bits are enough.
    assign w_coord[0] = i_in.coord_x[SUM_W-1:0];
    assign w_coord[1] = i_in.coord_y[SUM_W-1:0];
    assign w_coord[2] = i_in.coord_z[SUM_W-1:0];

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_sum[a] = w_coord[a] + SUM_W'(r_ofs[a]);
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cmd   <= {r_cmd[6:1], i_in.cmd};
            r_tidx1 <= i_in.table_index;
            r_tval1 <= i_in.table_value;
            r_tidx2 <= r_tidx1;
            r_tval2 <= r_tval1;
            r_tidx3 <= r_tidx2;
            r_tval3 <= r_tval2;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_f1[a] <= n_sum[a][FRAC_BITS-1:0];
                r_h1[a] <= n_sum[a][SUM_W-1:FRAC_BITS];
                r_f2[a] <= r_f1[a];
                r_f3[a] <= r_f2[a];
                r_f4[a] <= r_f3[a];
            end
            r_hy2 <= r_h1[1];
            r_hz2 <= r_h1[2];
            r_hz3 <= r_hz2;
            r_tx5 <= w_fade[0];
            r_ty5 <= w_fade[1];
            r_tz5 <= w_fade[2];
            r_ty6 <= r_ty5;
            r_tz6 <= r_tz5;
            r_tz7 <= r_tz6;
            for (int k = 0; k < 8; k++) begin
                r_l5[k] <= n_grad[k];
            end
            for (int j = 0; j < 4; j++) begin
                r_x6[j] <= n_x[j];
            end
            r_y7[0] <= n_y[0];
            r_y7[1] <= n_y[1];
            r_res   <= lerp(r_tz7, r_y7[0], r_y7[1]);
        end
    end

    // One fade unit per axis, aligned so the weights arrive with stage four.
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_fade
        pns_fade u_fade (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_frac (r_f1[a]),
            .o_fade (w_fade[a])
        );
    end

    // Each lookup level owns its table copies. A write item updates each copy as it
    // passes that copy's stage, so every sample sees the table as of its own transfer.
    assign w_we1 = w_adv && r_vld[1] && (r_cmd[1] == CMD_WRITE);
    assign w_we2 = w_adv && r_vld[2] && (r_cmd[2] == CMD_WRITE);
    assign w_we3 = w_adv && r_vld[3] && (r_cmd[3] == CMD_WRITE);

    pns_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl_l1 (
        .i_clk    (i_clk),
        .i_we     (w_we1),
        .i_waddr  (r_tidx1),
        .i_wdata  (r_tval1),
        .i_re     (w_adv),
        .i_raddr0 (r_h1[0]),
        .i_raddr1 (r_h1[0] + TBL_AW'(1)),
        .o_rdata0 (w_p1a),
        .o_rdata1 (w_p1b)
    );

    assign w_a1 = w_p1a + r_hy2;
    assign w_b1 = w_p1b + r_hy2;

    pns_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl_l2a (
        .i_clk    (i_clk),
        .i_we     (w_we2),
        .i_waddr  (r_tidx2),
        .i_wdata  (r_tval2),
        .i_re     (w_adv),
        .i_raddr0 (w_a1),
        .i_raddr1 (w_a1 + TBL_AW'(1)),
        .o_rdata0 (w_pa1),
        .o_rdata1 (w_pa11)
    );

    pns_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl_l2b (
        .i_clk    (i_clk),
        .i_we     (w_we2),
        .i_waddr  (r_tidx2),
        .i_wdata  (r_tval2),
        .i_re     (w_adv),
        .i_raddr0 (w_b1),
        .i_raddr1 (w_b1 + TBL_AW'(1)),
        .o_rdata0 (w_pb1),
        .o_rdata1 (w_pb11)
    );

    // Row hashes in corner order: a2, b2, a3, b3.
    assign w_l3a[0] = w_pa1  + r_hz3;
    assign w_l3a[1] = w_pb1  + r_hz3;
    assign w_l3a[2] = w_pa11 + r_hz3;
    assign w_l3a[3] = w_pb11 + r_hz3;

    // Copy j serves the near-z corner j and the far-z corner j + 4.
    for (genvar j = 0; j < 4; j++) begin : g_tbl_l3
        pns_ram #(.WIDTH(TBL_W), .DEPTH(TBL_DEPTH)) u_tbl_l3 (
            .i_clk    (i_clk),
            .i_we     (w_we3),
            .i_waddr  (r_tidx3),
            .i_wdata  (r_tval3),
            .i_re     (w_adv),
            .i_raddr0 (w_l3a[j]),
            .i_raddr1 (w_l3a[j] + TBL_AW'(1)),
            .o_rdata0 (w_hash[j]),
            .o_rdata1 (w_hash[j+4])
        );
    end

    // Corner offsets: the fraction itself, or the fraction minus one, which in this
    // width is the fraction with the sign bit set.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_pos[a] = $signed({1'b0, r_f4[a]});
            w_neg[a] = $signed({1'b1, r_f4[a]});
        end
        for (int k = 0; k < 8; k++) begin
            n_grad[k] = grad(w_hash[k][3:0],
                             k[0] ? w_neg[0] : w_pos[0],
                             k[1] ? w_neg[1] : w_pos[1],
                             k[2] ? w_neg[2] : w_pos[2]);
        end
    end

    // Trilinear blend, one axis per stage: x, then y, then z.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_x[j] = lerp(r_tx5, LERP_W'(r_l5[2*j]), LERP_W'(r_l5[2*j+1]));
        end
        n_y[0] = lerp(r_ty6, r_x6[0], r_x6[1]);
        n_y[1] = lerp(r_ty6, r_x6[2], r_x6[3]);
    end

    // Clamp the held sample to plus or minus two.
    assign w_res_ext = SAT_W'(r_res);

    always_comb begin
        priority if (w_res_ext > OUT_LIMIT) begin
            w_sat = OUT_LIMIT;
        end else if (w_res_ext < -OUT_LIMIT) begin
            w_sat = -OUT_LIMIT;
        end else begin
            w_sat = w_res_ext;
        end
    end

    assign o_res.valid       = r_ovld;
    assign o_res.noise_value = OUT_W'(w_sat);

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_res.valid)
        else $error("input stalled while the output register is empty");

    a_stall_freezes_stages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("stage valid bits moved during a stall");

    a_sample_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (SAT_W'(o_res.noise_value) <= OUT_LIMIT &&
                         SAT_W'(o_res.noise_value) >= -OUT_LIMIT))
        else $error("noise sample outside the clamp range");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/pns_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module pns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pns_fade.sv -----
// Three-stage pipelined quintic fade 6t^5 - 15t^4 + 10t^3 in fixed point.
`default_nettype none
module pns_fade import pns_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS-1:0] i_frac,
    output logic [FRAC_BITS:0]   o_fade
);
    logic signed [POLY_W-1:0]          w_k;
    logic signed [FRAC_BITS+POLY_W:0]  w_p1;
    logic [2*FRAC_BITS-1:0]            w_sq;
    logic [2*FRAC_BITS-1:0]            w_cu;
    logic [FRAC_BITS+POLY_W-1:0]       w_p4;

    logic signed [POLY_W-1:0]  r_m1;
    logic [FRAC_BITS-1:0]      r_sq;
    logic [FRAC_BITS-1:0]      r_f;
    logic [POLY_W-1:0]         r_inner;
    logic [FRAC_BITS-1:0]      r_cube;
    logic [FRAC_BITS:0]        r_fade;

    // 6t - 15 wraps correctly in the poly width since its value lies in [-15, -9).
    assign w_k  = $signed((POLY_W'(i_frac) * FADE_C6) - FADE_C15);
    assign w_p1 = (FRAC_BITS+POLY_W+1)'($signed({1'b0, i_frac}))
                * (FRAC_BITS+POLY_W+1)'(w_k);
    assign w_sq = (2*FRAC_BITS)'(i_frac) * (2*FRAC_BITS)'(i_frac);
    assign w_cu = (2*FRAC_BITS)'(r_sq) * (2*FRAC_BITS)'(r_f);
    // The inner term 6t^2 - 15t + 10 stays positive, so an unsigned product is exact.
    assign w_p4 = (FRAC_BITS+POLY_W)'(r_cube) * (FRAC_BITS+POLY_W)'(r_inner);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1    <= POLY_W'(w_p1 >>> FRAC_BITS);
            r_sq    <= w_sq[2*FRAC_BITS-1:FRAC_BITS];
            r_f     <= i_frac;
            r_inner <= $unsigned(r_m1) + FADE_C10;
            r_cube  <= w_cu[2*FRAC_BITS-1:FRAC_BITS];
            r_fade  <= w_p4[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign o_fade = r_fade;
endmodule
`default_nettype wire
